// ===== rtl/expression_lexer_defines.svh =====
// Assertion macros shared by the expression lexer checker.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef EXPRESSION_LEXER_DEFINES_SVH
`define EXPRESSION_LEXER_DEFINES_SVH

// Property checked on every rising edge, switched off while reset is low.
`define EXLEX_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Property checked on every rising edge, reset cycles included.
`define EXLEX_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/exlex_pkg.sv =====
// Shared types, constants and character helpers for the expression lexer.
// No dependencies; used by the token interface, the core, the queue and the checker.
package exlex_pkg;

  localparam int POS_W = 32;
  localparam int LEN_W = 8;
  localparam logic [LEN_W-1:0] LEN_MAX = 8'd255;

  // Token classes as seen on the result channel.
  typedef enum logic [4:0] {
    TK_LPAREN   = 5'd0,
    TK_RPAREN   = 5'd1,
    TK_PLUS     = 5'd2,
    TK_MINUS    = 5'd3,
    TK_MULT     = 5'd4,
    TK_DIV      = 5'd5,
    TK_POW      = 5'd6,
    TK_NUM      = 5'd7,
    TK_ERR      = 5'd8,
    TK_END      = 5'd9,
    TK_ID       = 5'd10,
    TK_SIN      = 5'd11,
    TK_COS      = 5'd12,
    TK_LOG      = 5'd13,
    TK_PI       = 5'd14,
    TK_E        = 5'd15,
    TK_SEMI     = 5'd16,
    TK_BIN      = 5'd17,
    TK_HEX      = 5'd18,
    TK_OCT      = 5'd19,
    TK_ASSIGN   = 5'd20,
    TK_PRINT    = 5'd21,
    TK_TRUE     = 5'd22,
    TK_FALSE    = 5'd23,
    TK_LT       = 5'd24,
    TK_GT       = 5'd25,
    TK_EQUAL    = 5'd26,
    TK_NOTEQUAL = 5'd27
  } tok_kind_t;

  // Scanner modes.
  typedef enum logic [3:0] {
    MD_IDLE    = 4'd0,
    MD_COMMENT = 4'd1,
    MD_EQ      = 4'd2,
    MD_BANG    = 4'd3,
    MD_STAR    = 4'd4,
    MD_IDENT   = 4'd5,
    MD_ZERO    = 4'd6,
    MD_BIN     = 4'd7,
    MD_HEX     = 4'd8,
    MD_OCT     = 4'd9,
    MD_DEC     = 4'd10
  } mode_t;

  typedef struct packed {
    tok_kind_t        kind;
    logic [POS_W-1:0] start;
    logic [LEN_W-1:0] len;
    logic             last;
  } token_t;

  // Up to two tokens produced by one input byte.
  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } push_t;

  // Character codes.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_B  = 8'h42;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_UP_O  = 8'h4F;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_B  = 8'h62;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_LO_O  = 8'h6F;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;

  // Keyword table, padded with zero bytes to eight characters per entry.
  localparam int KW_NUM = 8;
  localparam logic [7:0] KW_TEXT [KW_NUM][8] = '{
    '{"p", "r", "i", "n", "t", 8'h00, 8'h00, 8'h00},
    '{"T", "r", "u", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"F", "a", "l", "s", "e", 8'h00, 8'h00, 8'h00},
    '{"s", "i", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"c", "o", "s", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"l", "o", "g", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"p", "i", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [LEN_W-1:0] KW_LEN [KW_NUM] = '{
    8'd5, 8'd4, 8'd5, 8'd3, 8'd3, 8'd3, 8'd2, 8'd1
  };
  localparam tok_kind_t KW_KIND [KW_NUM] = '{
    TK_PRINT, TK_TRUE, TK_FALSE, TK_SIN, TK_COS, TK_LOG, TK_PI, TK_E
  };

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
  endfunction

  function automatic logic is_alnum(logic [7:0] c);
    return is_digit(c) || is_alpha(c);
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return is_digit(c) || ((c >= CH_LO_A) && (c <= CH_LO_F)) ||
           ((c >= CH_UP_A) && (c <= CH_UP_F));
  endfunction

  // Keywords that still agree with a character placed at offset idx.
  function automatic logic [KW_NUM-1:0] kw_keep(logic [7:0] c, logic [LEN_W-1:0] idx);
    logic [KW_NUM-1:0] keep;
    keep = '0;
    for (int k = 0; k < KW_NUM; k++) begin
      keep[k] = (idx < KW_LEN[k]) && (KW_TEXT[k][idx[2:0]] == c);
    end
    return keep;
  endfunction

  // Saturating length increment.
  function automatic logic [LEN_W-1:0] grow(logic [LEN_W-1:0] len);
    return (len == LEN_MAX) ? len : len + 1'b1;
  endfunction

  // True in the modes that hold a lexeme waiting for its end.
  function automatic logic mode_pending(mode_t m);
    return (m != MD_IDLE) && (m != MD_COMMENT);
  endfunction

  // Class of the pending lexeme when it is closed.
  function automatic tok_kind_t finish_kind(mode_t m, logic [KW_NUM-1:0] cand,
                                            logic [LEN_W-1:0] len);
    tok_kind_t kind;
    kind = TK_ERR;
    unique case (m)
      MD_EQ:   kind = TK_ASSIGN;
      MD_STAR: kind = TK_MULT;
      MD_IDENT: begin
        kind = TK_ID;
        for (int k = 0; k < KW_NUM; k++) begin
          if (cand[k] && (KW_LEN[k] == len)) kind = KW_KIND[k];
        end
      end
      MD_ZERO, MD_DEC: kind = TK_NUM;
      MD_BIN: kind = (len > 8'd2) ? TK_BIN : TK_ERR;
      MD_HEX: kind = (len > 8'd2) ? TK_HEX : TK_ERR;
      MD_OCT: kind = (len > 8'd2) ? TK_OCT : TK_ERR;
      default: kind = TK_ERR;
    endcase
    return kind;
  endfunction

endpackage

// ===== rtl/exlex_if.sv =====
// Valid/ready channel interfaces for the expression lexer: byte input, token output.
// Depends on exlex_pkg for field widths.
interface exlex_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

interface exlex_tok_if;
  import exlex_pkg::*;
  logic             valid;
  logic             ready;
  logic [4:0]       token_kind;
  logic [POS_W-1:0] token_start;
  logic [LEN_W-1:0] token_length;
  logic             last_of_run;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output last_of_run, input ready);
  modport sink (input valid, input token_kind, input token_start,
                input token_length, input last_of_run, output ready);
endinterface

// ===== rtl/exlex_core.sv =====
// Scanner core: byte input register, scanner state and the per-byte token logic.
// Depends on exlex_pkg; pushes up to two tokens per byte into the result queue.
module exlex_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [7:0]        in_char,
  output logic              in_ready,
  input  logic              room,
  output exlex_pkg::push_t  push
);
  import exlex_pkg::*;

  logic [7:0]        byte_r;
  logic              byte_vld_r;
  mode_t             mode_r, mode_nxt;
  logic [KW_NUM-1:0] cand_r, cand_nxt;
  logic [POS_W-1:0]  start_r, start_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              dp_r, dp_nxt;

  logic      fire;
  logic      take;
  logic      a_vld, b_vld;
  token_t    tok_a, tok_b;
  tok_kind_t fin_kind;

  // The held byte is scanned once the queue can take two more words.
  assign fire     = byte_vld_r && room;
  assign in_ready = !byte_vld_r || room;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      byte_vld_r <= 1'b1;
    end else if (fire) begin
      byte_vld_r <= 1'b0;
    end
    if (in_valid && in_ready) begin
      byte_r <= in_char;
    end
  end

  // Scanner state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MD_IDLE;
      cand_r  <= '1;
      start_r <= '0;
      len_r   <= '0;
      pos_r   <= '0;
      dp_r    <= 1'b0;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      cand_r  <= cand_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
      dp_r    <= dp_nxt;
    end
  end

  assign fin_kind = finish_kind(mode_r, cand_r, len_r);

  // Next state and the two token slots: slot A closes the pending lexeme,
  // slot B carries a token started and ended by this byte, or END.
  always_comb begin
    mode_nxt  = mode_r;
    cand_nxt  = cand_r;
    start_nxt = start_r;
    len_nxt   = len_r;
    pos_nxt   = pos_r + 1'b1;
    dp_nxt    = dp_r;
    take      = 1'b0;
    a_vld     = 1'b0;
    b_vld     = 1'b0;
    tok_a     = '0;
    tok_b     = '0;

    if (byte_r == CH_NUL) begin
      // End of input: flush, emit END, return to the reset state.
      a_vld       = mode_pending(mode_r);
      tok_a.kind  = fin_kind;
      tok_a.start = start_r;
      tok_a.len   = len_r;
      b_vld       = 1'b1;
      tok_b.kind  = TK_END;
      tok_b.start = pos_r;
      tok_b.len   = '0;
      mode_nxt    = MD_IDLE;
      cand_nxt    = '1;
      start_nxt   = '0;
      len_nxt     = '0;
      pos_nxt     = '0;
      dp_nxt      = 1'b0;
    end else begin
      // Try to extend the pending lexeme.
      unique case (mode_r)
        MD_COMMENT: begin
          take = 1'b1;
          if (byte_r == CH_LF) mode_nxt = MD_IDLE;
        end
        MD_EQ, MD_BANG, MD_STAR: begin
          if ((mode_r == MD_STAR) ? (byte_r == CH_STAR) : (byte_r == CH_EQ)) begin
            take        = 1'b1;
            a_vld       = 1'b1;
            tok_a.start = start_r;
            tok_a.len   = 8'd2;
            mode_nxt    = MD_IDLE;
            unique case (mode_r)
              MD_EQ:   tok_a.kind = TK_EQUAL;
              MD_BANG: tok_a.kind = TK_NOTEQUAL;
              default: tok_a.kind = TK_POW;
            endcase
          end
        end
        MD_IDENT: begin
          if (is_alnum(byte_r)) begin
            take     = 1'b1;
            cand_nxt = cand_r & kw_keep(byte_r, len_r);
            len_nxt  = grow(len_r);
          end
        end
        MD_ZERO: begin
          take    = 1'b1;
          len_nxt = grow(len_r);
          if ((byte_r == CH_LO_B) || (byte_r == CH_UP_B)) begin
            mode_nxt = MD_BIN;
          end else if ((byte_r == CH_LO_X) || (byte_r == CH_UP_X)) begin
            mode_nxt = MD_HEX;
          end else if ((byte_r == CH_LO_O) || (byte_r == CH_UP_O)) begin
            mode_nxt = MD_OCT;
          end else if (is_digit(byte_r) || (byte_r == CH_DOT)) begin
            mode_nxt = MD_DEC;
            if (byte_r == CH_DOT) dp_nxt = 1'b1;
          end else begin
            take    = 1'b0;
            len_nxt = len_r;
          end
        end
        MD_BIN: begin
          if ((byte_r == CH_ZERO) || (byte_r == CH_ONE)) begin
            take    = 1'b1;
            len_nxt = grow(len_r);
          end
        end
        MD_HEX: begin
          if (is_hex(byte_r)) begin
            take    = 1'b1;
            len_nxt = grow(len_r);
          end
        end
        MD_OCT: begin
          if ((byte_r >= CH_ZERO) && (byte_r <= CH_SEVEN)) begin
            take    = 1'b1;
            len_nxt = grow(len_r);
          end
        end
        MD_DEC: begin
          if (is_digit(byte_r) || ((byte_r == CH_DOT) && !dp_r)) begin
            take    = 1'b1;
            len_nxt = grow(len_r);
            if (byte_r == CH_DOT) dp_nxt = 1'b1;
          end
        end
        default: begin
          mode_nxt = MD_IDLE;
        end
      endcase

      // The byte did not extend the lexeme: close it and scan the byte afresh.
      if (!take) begin
        a_vld       = mode_pending(mode_r);
        tok_a.kind  = fin_kind;
        tok_a.start = start_r;
        tok_a.len   = len_r;
        mode_nxt    = MD_IDLE;
        tok_b.start = pos_r;
        tok_b.len   = 8'd1;
        tok_b.kind  = TK_ERR;

        unique case (byte_r)
          CH_SPACE, CH_TAB, CH_CR, CH_LF: ;
          CH_HASH: mode_nxt = MD_COMMENT;
          CH_EQ, CH_BANG, CH_STAR: begin
            start_nxt = pos_r;
            len_nxt   = 8'd1;
            dp_nxt    = 1'b0;
            unique case (byte_r)
              CH_EQ:   mode_nxt = MD_EQ;
              CH_BANG: mode_nxt = MD_BANG;
              default: mode_nxt = MD_STAR;
            endcase
          end
          CH_LT:    begin b_vld = 1'b1; tok_b.kind = TK_LT;     end
          CH_GT:    begin b_vld = 1'b1; tok_b.kind = TK_GT;     end
          CH_LPAR:  begin b_vld = 1'b1; tok_b.kind = TK_LPAREN; end
          CH_RPAR:  begin b_vld = 1'b1; tok_b.kind = TK_RPAREN; end
          CH_PLUS:  begin b_vld = 1'b1; tok_b.kind = TK_PLUS;   end
          CH_MINUS: begin b_vld = 1'b1; tok_b.kind = TK_MINUS;  end
          CH_SLASH: begin b_vld = 1'b1; tok_b.kind = TK_DIV;    end
          CH_SEMI:  begin b_vld = 1'b1; tok_b.kind = TK_SEMI;   end
          default: begin
            if (is_digit(byte_r) || is_alpha(byte_r)) begin
              start_nxt = pos_r;
              len_nxt   = 8'd1;
              dp_nxt    = 1'b0;
              if (is_alpha(byte_r)) begin
                mode_nxt = MD_IDENT;
                cand_nxt = kw_keep(byte_r, '0);
              end else if (byte_r == CH_ZERO) begin
                mode_nxt = MD_ZERO;
              end else begin
                mode_nxt = MD_DEC;
              end
            end else begin
              b_vld = 1'b1;
            end
          end
        endcase
      end
    end
  end

  // Pack the slots so the first valid token always sits in tok0.
  always_comb begin
    push.tok0      = a_vld ? tok_a : tok_b;
    push.tok0.last = !(a_vld && b_vld);
    push.tok1      = tok_b;
    push.tok1.last = 1'b1;
    push.count     = fire ? ({1'b0, a_vld} + {1'b0, b_vld}) : 2'd0;
  end

endmodule

// ===== rtl/exlex_fifo.sv =====
// Four-word token queue between the scanner core and the result channel.
// Depends on exlex_pkg; takes up to two words per cycle and hands out one.
module exlex_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  exlex_pkg::push_t  push,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output exlex_pkg::token_t head
);
  import exlex_pkg::*;

  token_t     entry_r [4];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] cnt_r;
  logic       pop;

  // Two free entries are needed before the core may scan a byte.
  assign room      = (cnt_r <= 3'd2);
  assign out_valid = (cnt_r != 3'd0);
  assign head      = entry_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) entry_r[wr_ptr_r] <= push.tok0;
    if (push.count == 2'd2) entry_r[wr_ptr_r + 2'd1] <= push.tok1;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + push.count;
      if (pop) rd_ptr_r <= rd_ptr_r + 2'd1;
      cnt_r <= cnt_r + {1'b0, push.count} - {2'b00, pop};
    end
  end

endmodule

// ===== rtl/expression_lexer.sv =====
// Expression lexer top level: byte stream in, token words out.
// Path: a byte is held in the input register, scanned, and its words written into the queue.
// Throughput: one byte per cycle while each byte yields at most one word and the sink
// takes every word; the single-word output port and the four-word queue set the rate when bytes yield two.
// Reset: synchronous, active low; clears scanner state, position and queued words.
module expression_lexer (
  input logic       clk,
  input logic       rst_n,
  exlex_char_if.sink  in_ch,
  exlex_tok_if.source out_ch
);
  import exlex_pkg::*;

  push_t  push;
  logic   room;
  token_t head;

  // Scanner core with its input register.
  exlex_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_char  (in_ch.char_code),
    .in_ready (in_ch.ready),
    .room     (room),
    .push     (push)
  );

  // Result queue.
  exlex_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .head      (head)
  );

  assign out_ch.token_kind   = head.kind;
  assign out_ch.token_start  = head.start;
  assign out_ch.token_length = head.len;
  assign out_ch.last_of_run  = head.last;

endmodule

// ===== rtl/exlex_checker.sv =====
// Port-level checks for the expression lexer, attached to the top level by bind.
// Depends on exlex_pkg and the macros in expression_lexer_defines.svh.
`include "expression_lexer_defines.svh"

module exlex_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [4:0] token_kind,
  input logic [31:0] token_start,
  input logic [7:0] token_length,
  input logic       last_of_run
);
  import exlex_pkg::*;

  logic        stall;
  logic        is_end;
  logic        is_tok;
  logic [45:0] word_bits;

  // Shorthands for the output word and its handshake state.
  assign stall     = out_valid && !out_ready;
  assign is_end    = out_valid && (token_kind == TK_END);
  assign is_tok    = out_valid && (token_kind != TK_END);
  assign word_bits = {token_kind, token_start, token_length, last_of_run};

  // A word that waits on the sink stays put.
  `EXLEX_ASSERT(a_out_hold, stall |=> out_valid && $stable(word_bits), "stalled word changed")

  // Reset empties the queue and frees the input register.
  `EXLEX_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid && in_ready, "reset left state behind")

  // END closes every run and has no lexeme.
  `EXLEX_ASSERT(a_end_form, is_end |-> token_length == 8'd0 && last_of_run, "malformed END word")

  // Every other token covers at least one byte.
  `EXLEX_ASSERT(a_tok_len, is_tok |-> token_length != 8'd0, "empty token")

endmodule

bind expression_lexer exlex_checker u_exlex_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .token_kind   (out_ch.token_kind),
  .token_start  (out_ch.token_start),
  .token_length (out_ch.token_length),
  .last_of_run  (out_ch.last_of_run)
);
